@@ design/bmprle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_pkg
// Shared types, constants and helpers of the 8-bit palette bitmap decoder.
// ----------------------------------------------------------------------------
package bmprle_pkg;

  localparam int DISPLAY_WIDTH  = 480;
  localparam int DISPLAY_HEIGHT = 320;
  localparam int PALETTE_DEPTH  = 256;
  localparam int PAL_AW         = $clog2(PALETTE_DEPTH);
  localparam int PAL_DW         = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_MODE  = 2'd2;

  localparam logic [11:0] IMG_WIDTH_RST  = 12'd480;
  localparam logic [11:0] IMG_HEIGHT_RST = 12'd320;
  localparam logic        COMP_MODE_RST  = 1'b0;

  localparam logic [1:0] KIND_PAL   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [11:0] img_width;
    logic [11:0] img_height;
    logic        rle;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] len;
    logic       lookup;
    logic       done;
  } res_t;

  function automatic logic idx_in_range(input logic [7:0] idx);
    return {1'b0, idx} < 9'(PALETTE_DEPTH);
  endfunction

  function automatic logic [15:0] sat_x_add(input logic [15:0] x, input logic [7:0] inc);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'b0, inc};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic logic signed [16:0] sat_y_sub(input logic signed [16:0] y,
                                                   input logic [7:0] dec);
    logic signed [17:0] diff;
    diff = $signed({y[16], y}) - $signed({10'b0, dec});
    return (diff < -18'sd65536) ? 17'h10000 : diff[16:0];
  endfunction

  function automatic logic visible(input logic [15:0] x, input logic signed [16:0] y);
    return (x < 16'(DISPLAY_WIDTH)) && !y[16] && (y[15:0] < 16'(DISPLAY_HEIGHT));
  endfunction

  function automatic logic [15:0] rgb565(input logic [PAL_DW-1:0] e);
    return {e[23:19], e[15:10], e[7:3]};
  endfunction

endpackage

@@ design/bmprle_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_in_if / bmprle_out_if
// Valid/ready channels for input items and run results.
// ----------------------------------------------------------------------------
interface bmprle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] entry_index;
  logic [7:0] entry_red;
  logic [7:0] entry_green;
  logic [7:0] entry_blue;

  modport source (output valid, kind, data_byte, entry_index, entry_red, entry_green,
                  entry_blue, input ready);
  modport sink (input valid, kind, data_byte, entry_index, entry_red, entry_green,
                entry_blue, output ready);
endinterface

interface bmprle_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [7:0]  run_length;
  logic [15:0] color;
  logic        image_done;

  modport source (output valid, pixel_x, pixel_y, run_length, color, image_done,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, run_length, color, image_done,
                output ready);
endinterface

@@ design/bmp8_rle8_pixel_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp8_rle8_pixel_decoder_core
// 8-bit palette bitmap decoder (uncompressed and RLE8) giving clipped
// RGB565 pixel runs with display coordinates.
//
//   channel     dir  handshake      carries
//   item_in_i   in   valid/ready    kind, data byte, palette entry
//   run_out_o   out  valid/ready    x, y, run length, color, image done
//   cfg_*       in   write enable   image width, image height, mode
//
// one item accepted per cycle while ready is high; a result passes through the
// lookup stage (palette ram read) and the output register
// the palette ram read port sets the extra stage; no clearing pass, entries
// are undefined until written
// reset clears the parser and the stage valids; config returns to 480x320
// a stalled output holds one result in the output register and one in the
// lookup stage before ready drops
// ----------------------------------------------------------------------------
module bmp8_rle8_pixel_decoder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  bmprle_in_if.sink                            item_in_i,
  bmprle_out_if.source                         run_out_o,
  input  logic                                 cfg_we_i,
  input  logic [bmprle_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bmprle_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  bmprle_pkg::cfg_t                  cfg_q;
  bmprle_pkg::item_t                 item;
  bmprle_pkg::res_t                  res;
  logic                              accept, in_ready, s1_valid, pal_we;
  logic [bmprle_pkg::PAL_DW-1:0]     rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_width  <= bmprle_pkg::IMG_WIDTH_RST;
      cfg_q.img_height <= bmprle_pkg::IMG_HEIGHT_RST;
      cfg_q.rle        <= bmprle_pkg::COMP_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmprle_pkg::CFG_IMG_WIDTH:  cfg_q.img_width  <= cfg_data_i;
        bmprle_pkg::CFG_IMG_HEIGHT: cfg_q.img_height <= cfg_data_i;
        bmprle_pkg::CFG_COMP_MODE:  cfg_q.rle        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item.kind        = item_in_i.kind;
  assign item.data_byte   = item_in_i.data_byte;
  assign item.entry_index = item_in_i.entry_index;
  assign item.entry_red   = item_in_i.entry_red;
  assign item.entry_green = item_in_i.entry_green;
  assign item.entry_blue  = item_in_i.entry_blue;

  assign item_in_i.ready = in_ready;
  assign accept = item_in_i.valid && in_ready;
  assign pal_we = accept && (item.kind == bmprle_pkg::KIND_PAL) &&
                  bmprle_pkg::idx_in_range(item.entry_index);

  bmprle_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  bmprle_ram #(
    .WIDTH (bmprle_pkg::PAL_DW),
    .DEPTH (bmprle_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (item.entry_index[bmprle_pkg::PAL_AW-1:0]),
    .wdata_i ({item.entry_red, item.entry_green, item.entry_blue}),
    .re_i    (accept),
    .raddr_i (item.data_byte[bmprle_pkg::PAL_AW-1:0]),
    .rdata_o (rdata)
  );

  bmprle_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_i      (res),
    .rdata_i    (rdata),
    .in_ready_o (in_ready),
    .s1_valid_o (s1_valid),
    .out_o      (run_out_o)
  );

  // a result without pixels only marks the end of the bitmap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_out_o.valid && (run_out_o.run_length == 8'd0) |-> run_out_o.image_done)
    else $error("empty run without image done");

  // empty runs carry zero position and color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_out_o.valid && (run_out_o.run_length == 8'd0) |->
      (run_out_o.pixel_x == 9'd0) && (run_out_o.pixel_y == 9'd0) &&
      (run_out_o.color == 16'd0))
    else $error("empty run with nonzero fields");

  // only data bytes give results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item.kind != bmprle_pkg::KIND_DATA) |=> !s1_valid)
    else $error("result from a non-data item");

endmodule

@@ design/bmprle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmprle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bmprle_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_parser
// Bitmap byte parser: cursor, RLE phase and row padding state, one item per
// cycle while items are accepted, giving the run that the accepted item causes.
// ----------------------------------------------------------------------------
module bmprle_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  bmprle_pkg::item_t   item_i,
  input  bmprle_pkg::cfg_t    cfg_i,
  output bmprle_pkg::res_t    res_o
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_DX      = 3'd2;
  localparam logic [2:0] PH_DY      = 3'd3;
  localparam logic [2:0] PH_ABS     = 3'd4;
  localparam logic [2:0] PH_ABS_PAD = 3'd5;
  localparam logic [2:0] PH_ROW_PAD = 3'd6;

  localparam logic signed [16:0] CUR_Y_RST = $signed({5'b0, bmprle_pkg::IMG_HEIGHT_RST}) - 17'sd1;

  logic [2:0]         phase_q, phase_d, phase_eff;
  logic [15:0]        cur_x_q, cur_x_d, x_inc;
  logic signed [16:0] cur_y_q, cur_y_d;
  logic [7:0]         first_q, first_d;
  logic [7:0]         rem_q, rem_d, rem_dec;
  logic [1:0]         pad_q, pad_d, pad_dec, row_pad;
  logic               fin_q, fin_d;
  logic               drawn, row_end, idx_ok;
  logic [15:0]        room;
  logic [7:0]         b;
  bmprle_pkg::res_t   res;

  assign b       = item_i.data_byte;
  assign idx_ok  = bmprle_pkg::idx_in_range(b);
  assign x_inc   = bmprle_pkg::sat_x_add(cur_x_q, 8'd1);
  assign pad_dec = (pad_q != 2'd0) ? pad_q - 2'd1 : pad_q;
  assign rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;
  assign row_pad = 2'd0 - cfg_i.img_width[1:0];
  assign drawn   = bmprle_pkg::visible(cur_x_q, cur_y_q);
  assign room    = 16'(bmprle_pkg::DISPLAY_WIDTH) - cur_x_q;
  assign phase_eff = (phase_q == PH_ROW_PAD) ? PH_FIRST : phase_q;

  always_comb begin
    phase_d = phase_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    first_d = first_q;
    rem_d   = rem_q;
    pad_d   = pad_q;
    fin_d   = fin_q;
    row_end = 1'b0;
    res     = '0;

    if (accept_i) begin
      case (item_i.kind)
        bmprle_pkg::KIND_START: begin
          phase_d = PH_FIRST;
          cur_x_d = '0;
          cur_y_d = $signed({5'b0, cfg_i.img_height}) - 17'sd1;
          first_d = '0;
          rem_d   = '0;
          pad_d   = '0;
          fin_d   = !cfg_i.rle && ((cfg_i.img_width == 12'd0) || (cfg_i.img_height == 12'd0));
        end
        bmprle_pkg::KIND_DATA: begin
          if (!fin_q && !cfg_i.rle) begin
            if (phase_q == PH_ROW_PAD) begin
              pad_d = pad_dec;
              if (pad_dec == 2'd0) begin
                row_end = 1'b1;
              end
            end else begin
              phase_d = PH_FIRST;
              cur_x_d = x_inc;
              if (drawn) begin
                res.valid  = 1'b1;
                res.len    = 8'd1;
                res.lookup = idx_ok;
              end
              if (x_inc >= {4'b0, cfg_i.img_width}) begin
                pad_d = row_pad;
                if (row_pad != 2'd0) begin
                  phase_d = PH_ROW_PAD;
                end else begin
                  row_end = 1'b1;
                end
              end
            end
            if (row_end) begin
              phase_d = PH_FIRST;
              cur_x_d = '0;
              if (cur_y_q <= 17'sd0) begin
                fin_d     = 1'b1;
                res.valid = 1'b1;
                res.done  = 1'b1;
              end else begin
                cur_y_d = cur_y_q - 17'sd1;
              end
            end
          end else if (!fin_q) begin
            phase_d = phase_eff;
            unique case (phase_eff)
              PH_SECOND: begin
                phase_d = PH_FIRST;
                if (first_q != 8'd0) begin
                  cur_x_d = bmprle_pkg::sat_x_add(cur_x_q, first_q);
                  if (drawn) begin
                    res.valid  = 1'b1;
                    res.len    = ({8'b0, first_q} < room) ? first_q : room[7:0];
                    res.lookup = idx_ok;
                  end
                end else begin
                  case (b)
                    bmprle_pkg::ESC_EOL: begin
                      cur_x_d = '0;
                      cur_y_d = bmprle_pkg::sat_y_sub(cur_y_q, 8'd1);
                    end
                    bmprle_pkg::ESC_EOB: begin
                      fin_d     = 1'b1;
                      res.valid = 1'b1;
                      res.done  = 1'b1;
                    end
                    bmprle_pkg::ESC_DELTA: begin
                      phase_d = PH_DX;
                    end
                    default: begin
                      rem_d   = b;
                      pad_d   = {1'b0, b[0]};
                      phase_d = PH_ABS;
                    end
                  endcase
                end
              end
              PH_DX: begin
                cur_x_d = bmprle_pkg::sat_x_add(cur_x_q, b);
                phase_d = PH_DY;
              end
              PH_DY: begin
                cur_y_d = bmprle_pkg::sat_y_sub(cur_y_q, b);
                phase_d = PH_FIRST;
              end
              PH_ABS: begin
                cur_x_d = x_inc;
                rem_d   = rem_dec;
                if (rem_dec == 8'd0) begin
                  phase_d = (pad_q != 2'd0) ? PH_ABS_PAD : PH_FIRST;
                end
                if (drawn) begin
                  res.valid  = 1'b1;
                  res.len    = 8'd1;
                  res.lookup = idx_ok;
                end
              end
              PH_ABS_PAD: begin
                pad_d   = '0;
                phase_d = PH_FIRST;
              end
              default: begin
                first_d = b;
                phase_d = PH_SECOND;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    // runs with no pixels carry zero coordinates
    if (res.len != 8'd0) begin
      res.x = cur_x_q[8:0];
      res.y = cur_y_q[8:0];
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      cur_x_q <= '0;
      cur_y_q <= CUR_Y_RST;
      first_q <= '0;
      rem_q   <= '0;
      pad_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      first_q <= first_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
    end
  end

endmodule

@@ design/bmprle_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_pipe
// Lookup stage and output register: waits for the palette read, forms the
// RGB565 color and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module bmprle_pipe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  bmprle_pkg::res_t                   res_i,
  input  logic [bmprle_pkg::PAL_DW-1:0]      rdata_i,
  output logic                               in_ready_o,
  output logic                               s1_valid_o,
  bmprle_out_if.source                       out_o
);

  bmprle_pkg::res_t s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             adv;
  logic [8:0]       x_q, y_q;
  logic [7:0]       len_q;
  logic [15:0]      color_q;
  logic             done_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_ready_o = !s1_valid_q || adv;
  assign s1_valid_o = s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = res_i.valid;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= res_i;
    end
    if (adv && s1_valid_q) begin
      x_q     <= s1_q.x;
      y_q     <= s1_q.y;
      len_q   <= s1_q.len;
      color_q <= s1_q.lookup ? bmprle_pkg::rgb565(rdata_i) : 16'd0;
      done_q  <= s1_q.done;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_x    = x_q;
  assign out_o.pixel_y    = y_q;
  assign out_o.run_length = len_q;
  assign out_o.color      = color_q;
  assign out_o.image_done = done_q;

endmodule
